>>> rtl/adjacency_matrix_dfs_order_unit_defines.svh
// Assertion macros used by the checker file of the depth-first order unit.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef ADJACENCY_MATRIX_DFS_ORDER_UNIT_DEFINES_SVH
`define ADJACENCY_MATRIX_DFS_ORDER_UNIT_DEFINES_SVH

// Clocked assertion that is switched off while reset is high.
`define AMDFS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that is checked at every edge, reset included.
`define AMDFS_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/amdfs_pkg.sv
// Package of the depth-first order unit: field widths, codes and control structs.
// Depends on nothing; every other source file of the block but the defines header imports it.
`timescale 1ns / 1ps
`default_nettype none

package amdfs_pkg;

   localparam int NODE_W              = 6;
   localparam int FUNC_W              = 2;
   localparam int STATUS_W            = 2;
   localparam int COUNT_W             = 7;
   localparam int CSR_ADDR_W          = 3;
   localparam int CSR_DATA_W          = 32;
   localparam int NODES_DEFAULT       = 64;
   localparam int STACK_DEPTH_DEFAULT = 256;

   localparam logic [COUNT_W-1:0] NODE_COUNT_RESET = 7'd64;

   // Register select bit of the configuration address (byte address 4*i).
   localparam logic CSR_IDX_NODE_COUNT = 1'b0;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_ADD_EDGE = 2'd0,
      FUNC_TRAVERSE = 2'd1,
      FUNC_CLEAR    = 2'd2,
      FUNC_NOP      = 2'd3
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK       = 2'd0,
      STATUS_RANGE    = 2'd1,
      STATUS_OVERFLOW = 2'd2
   } status_type;

   typedef struct packed {
      logic rd_en;
      logic wr_en;
      logic clear_all;
   } adj_ctrl_type;

   typedef struct packed {
      logic rd_en;
      logic wr_en;
   } stk_ctrl_type;

endpackage

`default_nettype wire

>>> rtl/amdfs_if.sv
// Valid/ready channel interfaces for the request and response beats.
// Depends on amdfs_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface amdfs_req_if;
   import amdfs_pkg::*;

   logic                valid;
   logic                ready;
   logic [FUNC_W-1:0]   func;
   logic [NODE_W-1:0]   from_node;
   logic [NODE_W-1:0]   to_node;

   modport source (output valid, output func, output from_node, output to_node,
                   input ready);
   modport sink   (input valid, input func, input from_node, input to_node,
                   output ready);
endinterface

interface amdfs_rsp_if;
   import amdfs_pkg::*;

   logic                valid;
   logic                ready;
   logic [NODE_W-1:0]   node;
   logic                last;
   logic [STATUS_W-1:0] status;

   modport source (output valid, output node, output last, output status,
                   input ready);
   modport sink   (input valid, input node, input last, input status,
                   output ready);
endinterface

`default_nettype wire

>>> rtl/amdfs_adj_mem.sv
// Adjacency row memory: one row per node, registered read, per-row valid bits.
// Depends on amdfs_pkg for the control struct and node width.
`timescale 1ns / 1ps
`default_nettype none

module amdfs_adj_mem #(
   parameter int NODES = amdfs_pkg::NODES_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  amdfs_pkg::adj_ctrl_type      ctrl,
   input  logic [amdfs_pkg::NODE_W-1:0] addr,
   input  logic [NODES-1:0]             wdata,
   output logic [NODES-1:0]             rdata
);
   import amdfs_pkg::*;

   localparam int ADDR_W = $clog2(NODES);

   logic [NODES-1:0]  row_mem_ff [NODES];
   logic [NODES-1:0]  rdata_ff;
   logic              rvalid_ff;
   logic [NODES-1:0]  row_valid_ff;
   logic [NODES-1:0]  row_valid_in;
   logic [ADDR_W-1:0] row_idx;

   assign row_idx = addr[ADDR_W-1:0];

   // A row that was never written since the last clear reads as all zeros.
   always_comb begin
      row_valid_in = row_valid_ff;
      if (ctrl.clear_all) begin
         row_valid_in = '0;
      end else if (ctrl.wr_en) begin
         row_valid_in[row_idx] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
         rvalid_ff    <= 1'b0;
      end else begin
         row_valid_ff <= row_valid_in;
         if (ctrl.rd_en) begin
            rvalid_ff <= row_valid_ff[row_idx];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.wr_en) begin
         row_mem_ff[row_idx] <= wdata;
      end
      if (ctrl.rd_en) begin
         rdata_ff <= row_mem_ff[row_idx];
      end
   end

   assign rdata = rvalid_ff ? rdata_ff : '0;

endmodule

`default_nettype wire

>>> rtl/amdfs_stack_mem.sv
// Node stack memory: one write and one registered read per cycle.
// Depends on amdfs_pkg for the control struct and node width.
`timescale 1ns / 1ps
`default_nettype none

module amdfs_stack_mem #(
   parameter int STACK_DEPTH = amdfs_pkg::STACK_DEPTH_DEFAULT
) (
   input  logic                           clock,
   input  amdfs_pkg::stk_ctrl_type        ctrl,
   input  logic [$clog2(STACK_DEPTH)-1:0] waddr,
   input  logic [$clog2(STACK_DEPTH)-1:0] raddr,
   input  logic [amdfs_pkg::NODE_W-1:0]   wdata,
   output logic [amdfs_pkg::NODE_W-1:0]   rdata
);
   import amdfs_pkg::*;

   logic [NODE_W-1:0] stack_mem_ff [STACK_DEPTH];
   logic [NODE_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (ctrl.wr_en) begin
         stack_mem_ff[waddr] <= wdata;
      end
      if (ctrl.rd_en) begin
         rdata_ff <= stack_mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

>>> rtl/amdfs_seq.sv
// Sequencer of the depth-first order unit: edge loads, stack pops and the
// neighbour scan that pushes one candidate per cycle. Depends on amdfs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module amdfs_seq #(
   parameter int NODES       = amdfs_pkg::NODES_DEFAULT,
   parameter int STACK_DEPTH = amdfs_pkg::STACK_DEPTH_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [amdfs_pkg::COUNT_W-1:0]  node_count,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [amdfs_pkg::FUNC_W-1:0]   req_func,
   input  logic [amdfs_pkg::NODE_W-1:0]   req_from,
   input  logic [amdfs_pkg::NODE_W-1:0]   req_to,
   input  logic                           res_free,
   output logic                           res_valid,
   output logic [amdfs_pkg::NODE_W-1:0]   res_node,
   output logic                           res_last,
   output logic [amdfs_pkg::STATUS_W-1:0] res_status,
   output amdfs_pkg::adj_ctrl_type        adj_ctrl,
   output logic [amdfs_pkg::NODE_W-1:0]   adj_addr,
   output logic [NODES-1:0]               adj_wdata,
   input  logic [NODES-1:0]               adj_rdata,
   output amdfs_pkg::stk_ctrl_type        stk_ctrl,
   output logic [$clog2(STACK_DEPTH)-1:0] stk_waddr,
   output logic [$clog2(STACK_DEPTH)-1:0] stk_raddr,
   output logic [amdfs_pkg::NODE_W-1:0]   stk_wdata,
   input  logic [amdfs_pkg::NODE_W-1:0]   stk_rdata
);
   import amdfs_pkg::*;

   localparam int ADDR_W = $clog2(NODES);
   localparam int SP_W   = $clog2(STACK_DEPTH);
   localparam int FILL_W = $clog2(STACK_DEPTH + 1);

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_EDGE = 6'b000010,
      ST_POP  = 6'b000100,
      ST_NODE = 6'b001000,
      ST_LOAD = 6'b010000,
      ST_SCAN = 6'b100000
   } state_type;

   // Highest set bit of the candidate word.
   function automatic logic [ADDR_W-1:0] top_index(input logic [NODES-1:0] bits);
      logic [ADDR_W-1:0] idx;
      idx = '0;
      for (int i = 0; i < NODES; i++) begin
         if (bits[i]) begin
            idx = ADDR_W'(i);
         end
      end
      return idx;
   endfunction

   state_type         state_ff, state_in;
   logic [NODES-1:0]  visited_ff, visited_in;
   logic [NODES-1:0]  cand_ff, cand_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic              overflow_ff, overflow_in;
   logic              pend_valid_ff, pend_valid_in;
   logic [NODE_W-1:0] pend_node_ff, pend_node_in;
   logic [NODE_W-1:0] edge_from_ff, edge_from_in;
   logic [NODE_W-1:0] edge_to_ff, edge_to_in;

   logic [COUNT_W-1:0] n_eff;
   logic [NODES-1:0]   live_mask;
   logic               accept;
   logic               from_bad;
   logic               to_bad;
   logic [ADDR_W-1:0]  v_idx;
   logic               v_seen;
   logic [ADDR_W-1:0]  scan_idx;
   logic               stack_full;
   logic [FILL_W-1:0]  fill_dec;

   // A count of zero acts as one node, anything above NODES acts as NODES.
   always_comb begin
      if (node_count == '0) begin
         n_eff = COUNT_W'(1);
      end else if (node_count > COUNT_W'(NODES)) begin
         n_eff = COUNT_W'(NODES);
      end else begin
         n_eff = node_count;
      end
      for (int i = 0; i < NODES; i++) begin
         live_mask[i] = (COUNT_W'(i) < n_eff);
      end
   end

   assign req_ready  = (state_ff == ST_IDLE) && res_free;
   assign accept     = req_valid && req_ready;
   assign from_bad   = (COUNT_W'(req_from) >= n_eff);
   assign to_bad     = (COUNT_W'(req_to) >= n_eff);
   assign v_idx      = stk_rdata[ADDR_W-1:0];
   assign v_seen     = visited_ff[v_idx];
   assign scan_idx   = top_index(cand_ff);
   assign stack_full = (fill_ff == FILL_W'(STACK_DEPTH));
   assign fill_dec   = fill_ff - FILL_W'(1);

   always_comb begin
      state_in      = state_ff;
      visited_in    = visited_ff;
      cand_in       = cand_ff;
      fill_in       = fill_ff;
      overflow_in   = overflow_ff;
      pend_valid_in = pend_valid_ff;
      pend_node_in  = pend_node_ff;
      edge_from_in  = edge_from_ff;
      edge_to_in    = edge_to_ff;
      res_valid     = 1'b0;
      res_node      = '0;
      res_last      = 1'b0;
      res_status    = STATUS_OK;
      adj_ctrl      = '0;
      adj_addr      = '0;
      adj_wdata     = '0;
      stk_ctrl      = '0;
      stk_waddr     = fill_ff[SP_W-1:0];
      stk_raddr     = fill_dec[SP_W-1:0];
      stk_wdata     = '0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_func)
                  FUNC_ADD_EDGE: begin
                     if (from_bad || to_bad) begin
                        res_valid  = 1'b1;
                        res_last   = 1'b1;
                        res_status = STATUS_RANGE;
                     end else begin
                        adj_ctrl.rd_en = 1'b1;
                        adj_addr       = req_from;
                        edge_from_in   = req_from;
                        edge_to_in     = req_to;
                        state_in       = ST_EDGE;
                     end
                  end
                  FUNC_TRAVERSE: begin
                     if (from_bad) begin
                        res_valid  = 1'b1;
                        res_last   = 1'b1;
                        res_status = STATUS_RANGE;
                     end else begin
                        visited_in     = '0;
                        overflow_in    = 1'b0;
                        pend_valid_in  = 1'b0;
                        stk_ctrl.wr_en = 1'b1;
                        stk_waddr      = '0;
                        stk_wdata      = req_from;
                        fill_in        = FILL_W'(1);
                        state_in       = ST_POP;
                     end
                  end
                  FUNC_CLEAR: begin
                     adj_ctrl.clear_all = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_EDGE: begin
            adj_ctrl.wr_en = 1'b1;
            adj_addr       = edge_from_ff;
            adj_wdata      = adj_rdata | (NODES'(1) << edge_to_ff[ADDR_W-1:0]);
            state_in       = ST_IDLE;
         end
         ST_POP: begin
            if (fill_ff == '0) begin
               // Stack drained: the held node is the final result.
               if (res_free) begin
                  res_valid     = 1'b1;
                  res_node      = pend_node_ff;
                  res_last      = 1'b1;
                  res_status    = overflow_ff ? STATUS_OVERFLOW : STATUS_OK;
                  pend_valid_in = 1'b0;
                  state_in      = ST_IDLE;
               end
            end else begin
               stk_ctrl.rd_en = 1'b1;
               fill_in        = fill_dec;
               state_in       = ST_NODE;
            end
         end
         ST_NODE: begin
            if (!(!v_seen && pend_valid_ff && !res_free)) begin
               if (!v_seen) begin
                  visited_in[v_idx] = 1'b1;
                  if (pend_valid_ff) begin
                     res_valid = 1'b1;
                     res_node  = pend_node_ff;
                  end
                  pend_node_in  = stk_rdata;
                  pend_valid_in = 1'b1;
               end
               adj_ctrl.rd_en = 1'b1;
               adj_addr       = stk_rdata;
               state_in       = ST_LOAD;
            end
         end
         ST_LOAD: begin
            cand_in  = adj_rdata & live_mask & ~visited_ff;
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (cand_ff == '0) begin
               state_in = ST_POP;
            end else begin
               cand_in[scan_idx] = 1'b0;
               if (stack_full) begin
                  overflow_in = 1'b1;
               end else begin
                  stk_ctrl.wr_en = 1'b1;
                  stk_wdata      = NODE_W'(scan_idx);
                  fill_in        = fill_ff + FILL_W'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         visited_ff    <= '0;
         fill_ff       <= '0;
         overflow_ff   <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         visited_ff    <= visited_in;
         fill_ff       <= fill_in;
         overflow_ff   <= overflow_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cand_ff      <= cand_in;
      pend_node_ff <= pend_node_in;
      edge_from_ff <= edge_from_in;
      edge_to_ff   <= edge_to_in;
   end

endmodule

`default_nettype wire

>>> rtl/adjacency_matrix_dfs_order_unit.sv
// Top level of the depth-first order unit: configuration register, response
// register and the sequencer with its two memories. Depends on amdfs_pkg,
// amdfs_if, amdfs_adj_mem, amdfs_stack_mem and amdfs_seq.
//
// Usage. Request beats on req_bus carry func, from_node and to_node. An add
// beat sets one edge of the adjacency matrix and gives no response unless a
// node is out of range. A clear beat empties the matrix. A
// traverse beat walks the graph depth first from from_node and returns one
// response beat per reached node on rsp_bus, the final one flagged by last
// and carrying status 2 if pushes were dropped on a full stack. Out-of-range
// nodes give a single beat with node 0, last 1 and status 1.
// Flow. An add holds the block while it reads and rewrites the source row;
// a clear or an error leaves it idle. An error beat shows on rsp_bus in the
// cycle after its request is taken. A traversal holds the block until its
// stack drains: the sequencer pops a node, reads its adjacency row and pushes
// one unvisited live neighbor per cycle through the highest-bit scan (dropped
// on a full stack); the final beat shows in the cycle it returns to idle.
// The block accepts one request at a time; req_bus.ready stays low until the
// current request is finished and the output register can take a beat.
// Stalls. Responses leave through one output register. While rsp_bus.ready
// is low and that register is full, the sequencer holds before producing the
// next response. Reset clears the matrix (row valid bits), the visited marks,
// the stack and the output register; node_count returns to 64.

`timescale 1ns / 1ps
`default_nettype none

module adjacency_matrix_dfs_order_unit #(
   parameter int NODES       = amdfs_pkg::NODES_DEFAULT,
   parameter int STACK_DEPTH = amdfs_pkg::STACK_DEPTH_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   amdfs_req_if.sink                        req_bus,
   amdfs_rsp_if.source                      rsp_bus,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [amdfs_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [amdfs_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [amdfs_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                             csr_pready
);
   import amdfs_pkg::*;

   localparam int SP_W = $clog2(STACK_DEPTH);

   logic [COUNT_W-1:0]  node_count_ff, node_count_in;
   logic                out_valid_ff, out_valid_in;
   logic [NODE_W-1:0]   out_node_ff, out_node_in;
   logic                out_last_ff, out_last_in;
   logic [STATUS_W-1:0] out_status_ff, out_status_in;

   logic                csr_sel_count;
   logic                csr_wr;
   logic                res_free;
   logic                res_valid;
   logic [NODE_W-1:0]   res_node;
   logic                res_last;
   logic [STATUS_W-1:0] res_status;
   adj_ctrl_type        adj_ctrl;
   logic [NODE_W-1:0]   adj_addr;
   logic [NODES-1:0]    adj_wdata;
   logic [NODES-1:0]    adj_rdata;
   stk_ctrl_type        stk_ctrl;
   logic [SP_W-1:0]     stk_waddr;
   logic [SP_W-1:0]     stk_raddr;
   logic [NODE_W-1:0]   stk_wdata;
   logic [NODE_W-1:0]   stk_rdata;

   // The configuration port never waits. The register select bit sits just
   // above the byte offset; the other select value is an empty hole.
   assign csr_pready    = 1'b1;
   assign csr_sel_count = (csr_paddr[CSR_ADDR_W-1] == CSR_IDX_NODE_COUNT);
   assign csr_wr        = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata    = csr_sel_count ? CSR_DATA_W'(node_count_ff) : '0;

   always_comb begin
      node_count_in = node_count_ff;
      if (csr_wr && csr_sel_count) begin
         node_count_in = csr_pwdata[COUNT_W-1:0];
      end
   end

   // The output register can take a new beat when it is empty or when its
   // current beat leaves in this cycle.
   assign res_free = !out_valid_ff || rsp_bus.ready;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_node_in   = out_node_ff;
      out_last_in   = out_last_ff;
      out_status_in = out_status_ff;
      if (res_valid) begin
         out_valid_in  = 1'b1;
         out_node_in   = res_node;
         out_last_in   = res_last;
         out_status_in = res_status;
      end else if (rsp_bus.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= NODE_COUNT_RESET;
         out_valid_ff  <= 1'b0;
      end else begin
         node_count_ff <= node_count_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_node_ff   <= out_node_in;
      out_last_ff   <= out_last_in;
      out_status_ff <= out_status_in;
   end

   assign rsp_bus.valid  = out_valid_ff;
   assign rsp_bus.node   = out_node_ff;
   assign rsp_bus.last   = out_last_ff;
   assign rsp_bus.status = out_status_ff;

   amdfs_seq #(
      .NODES       (NODES),
      .STACK_DEPTH (STACK_DEPTH)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .node_count (node_count_ff),
      .req_valid  (req_bus.valid),
      .req_ready  (req_bus.ready),
      .req_func   (req_bus.func),
      .req_from   (req_bus.from_node),
      .req_to     (req_bus.to_node),
      .res_free   (res_free),
      .res_valid  (res_valid),
      .res_node   (res_node),
      .res_last   (res_last),
      .res_status (res_status),
      .adj_ctrl   (adj_ctrl),
      .adj_addr   (adj_addr),
      .adj_wdata  (adj_wdata),
      .adj_rdata  (adj_rdata),
      .stk_ctrl   (stk_ctrl),
      .stk_waddr  (stk_waddr),
      .stk_raddr  (stk_raddr),
      .stk_wdata  (stk_wdata),
      .stk_rdata  (stk_rdata)
   );

   amdfs_adj_mem #(
      .NODES (NODES)
   ) u_adj_mem (
      .clock (clock),
      .reset (reset),
      .ctrl  (adj_ctrl),
      .addr  (adj_addr),
      .wdata (adj_wdata),
      .rdata (adj_rdata)
   );

   amdfs_stack_mem #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_stack_mem (
      .clock (clock),
      .ctrl  (stk_ctrl),
      .waddr (stk_waddr),
      .raddr (stk_raddr),
      .wdata (stk_wdata),
      .rdata (stk_rdata)
   );

endmodule

`default_nettype wire

>>> rtl/amdfs_checker.sv
// Port-level checker of the depth-first order unit and its bind statement.
// Depends on amdfs_pkg and adjacency_matrix_dfs_order_unit_defines.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "adjacency_matrix_dfs_order_unit_defines.svh"

module amdfs_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_ready,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [amdfs_pkg::NODE_W-1:0]   rsp_node,
   input logic                           rsp_last,
   input logic [amdfs_pkg::STATUS_W-1:0] rsp_status
);
   import amdfs_pkg::*;

   // A response beat that is not taken stays offered.
   `AMDFS_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid, "response dropped while stalled")

   // A request is only taken when the response register can absorb its answer.
   `AMDFS_ASSERT(a_ready_needs_slot, clock, reset, req_ready |-> !rsp_valid || rsp_ready, "request taken with a full response register")

   // Error and overflow status only ever appear on the final beat.
   `AMDFS_ASSERT(a_status_on_last, clock, reset, rsp_valid && rsp_status != STATUS_OK |-> rsp_last, "non-zero status on a beat that is not last")

   // Range errors report node zero.
   `AMDFS_ASSERT(a_range_node_zero, clock, reset, rsp_valid && rsp_status == STATUS_RANGE |-> rsp_node == '0, "range error with non-zero node")

   // Reset empties the response register.
   `AMDFS_ASSERT_ALWAYS(a_reset_empty, clock, $past(reset) |-> !rsp_valid, "response valid right after reset")

endmodule

bind adjacency_matrix_dfs_order_unit amdfs_checker u_amdfs_checker (
   .clock      (clock),
   .reset      (reset),
   .req_ready  (req_bus.ready),
   .rsp_valid  (rsp_bus.valid),
   .rsp_ready  (rsp_bus.ready),
   .rsp_node   (rsp_bus.node),
   .rsp_last   (rsp_bus.last),
   .rsp_status (rsp_bus.status)
);

`default_nettype wire

>>> verif/tb.sv
// Self-checking testbench for adjacency_matrix_dfs_order_unit: edge loads, clears and
// depth-first traversals checked beat by beat against a behavioral predictor.
// Depends on amdfs_pkg, amdfs_if and the RTL of the block.
`timescale 1ns / 1ps

module tb;
   import amdfs_pkg::*;

   // The block is built at its default sizes.
   localparam int NODES         = NODES_DEFAULT;
   localparam int STACK_ENTRIES = STACK_DEPTH_DEFAULT;
   // Idle cycles after the last expected beat, so a trailing add can finish.
   localparam int SETTLE_CYCLES = 40;
   // Byte address of the node count register.
   localparam int NODE_COUNT_ADDR = 4 * CSR_IDX_NODE_COUNT;
   localparam int PHASES = 9;
   localparam int PHASE_ITEMS = 14;

   typedef struct packed {
      func_type          func;
      logic [NODE_W-1:0] from_node;
      logic [NODE_W-1:0] to_node;
   } dfs_request_type;

   typedef struct {
      logic [NODE_W-1:0] node;
      logic              last;
      status_type        status;
   } visit_beat_type;

   logic clock = 1'b0;
   logic reset;

   amdfs_req_if req_bus ();
   amdfs_rsp_if rsp_bus ();

   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   adjacency_matrix_dfs_order_unit #(
      .NODES       (NODES),
      .STACK_DEPTH (STACK_ENTRIES)
   ) i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #2 clock = ~clock;

   // ---------------------------------------------------------------------
   // Shadow state of the block. It is advanced once per accepted request
   // beat, in acceptance order, and once per register write.
   // ---------------------------------------------------------------------
   logic [NODES-1:0]  adj_rows [NODES];
   logic [NODES-1:0]  visited_nodes;
   logic [NODE_W-1:0] shadow_stack [STACK_ENTRIES];
   int unsigned       stack_level;
   logic              push_dropped;
   logic [COUNT_W-1:0] node_count_shadow;

   dfs_request_type pending_requests [$];
   visit_beat_type  expected_visits [$];
   dfs_request_type beat_on_bus;
   visit_beat_type  oldest_visit;

   int unsigned send_idle_pct;
   int unsigned recv_idle_pct;
   int unsigned queued_items;
   int unsigned accepted_requests;
   int unsigned checked_visits;
   int unsigned mismatch_count;
   int unsigned traversal_count;
   int unsigned overflow_count;
   int unsigned range_error_count;
   int unsigned settings_used;

   int unsigned phase_node_counts [PHASES] = '{64, 8, 127, 2, 1, 33, 0, 64, 17};

   // A register value of zero behaves as one node, anything above NODES as NODES.
   function automatic int unsigned effective_nodes();
      if (node_count_shadow == 0) return 1;
      if (node_count_shadow > NODES) return NODES;
      return node_count_shadow;
   endfunction

   function automatic void push_shadow(logic [NODE_W-1:0] node);
      if (stack_level >= STACK_ENTRIES) begin
         push_dropped = 1'b1;
      end else begin
         shadow_stack[stack_level] = node;
         stack_level++;
      end
   endfunction

   function automatic void expect_range_error();
      visit_beat_type beat;
      beat.node   = '0;
      beat.last   = 1'b1;
      beat.status = STATUS_RANGE;
      expected_visits.push_back(beat);
      range_error_count++;
   endfunction

   // Works out the response beats of one request and updates the shadow state.
   function automatic void predict_dfs_visits(dfs_request_type r);
      int unsigned       n;
      logic [NODES-1:0]  live_mask;
      logic [NODES-1:0]  candidates;
      logic [NODE_W-1:0] node;
      logic [NODE_W-1:0] visit_order [$];
      visit_beat_type    beat;
      n = effective_nodes();
      live_mask = (n >= NODES) ? {NODES{1'b1}} : ((64'd1 << n) - 64'd1);
      case (r.func)
         FUNC_ADD_EDGE: begin
            if (r.from_node >= n || r.to_node >= n) expect_range_error();
            else adj_rows[r.from_node][r.to_node] = 1'b1;
         end
         FUNC_CLEAR: begin
            for (int i = 0; i < NODES; i++) adj_rows[i] = '0;
         end
         FUNC_TRAVERSE: begin
            if (r.from_node >= n) begin
               expect_range_error();
            end else begin
               traversal_count++;
               visited_nodes = '0;
               stack_level   = 0;
               push_dropped  = 1'b0;
               push_shadow(r.from_node);
               while (stack_level > 0) begin
                  stack_level--;
                  node = shadow_stack[stack_level];
                  if (node >= n) continue;
                  if (!visited_nodes[node]) begin
                     visited_nodes[node] = 1'b1;
                     visit_order.push_back(node);
                  end
                  // Pushing from the top index down leaves the lowest neighbor on top.
                  candidates = adj_rows[node] & live_mask & ~visited_nodes;
                  for (int i = NODES - 1; i >= 0; i--) begin
                     if (candidates[i]) push_shadow(NODE_W'(i));
                  end
               end
               if (push_dropped) overflow_count++;
               foreach (visit_order[k]) begin
                  beat.node   = visit_order[k];
                  beat.last   = (k == visit_order.size() - 1);
                  beat.status = (beat.last && push_dropped) ? STATUS_OVERFLOW : STATUS_OK;
                  expected_visits.push_back(beat);
               end
            end
         end
         default: ;
      endcase
   endfunction

   task automatic report_mismatch(string what);
      $display("mismatch at %0t: %s", $realtime, what);
      mismatch_count++;
   endtask

   // ---------------------------------------------------------------------
   // Request driver. A beat stays on the bus until it is accepted; after an
   // accepted beat the next one may follow at once or after random idle
   // cycles, so gaps land on every phase of the block's work.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            predict_dfs_visits(beat_on_bus);
            accepted_requests++;
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               beat_on_bus = pending_requests.pop_front();
               req_bus.func      <= beat_on_bus.func;
               req_bus.from_node <= beat_on_bus.from_node;
               req_bus.to_node   <= beat_on_bus.to_node;
               req_bus.valid     <= 1'b1;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Response monitor. Every accepted beat is matched against the oldest
   // expected visit, field by field. The ready line stalls at random.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            checked_visits++;
            if (expected_visits.size() == 0) begin
               report_mismatch($sformatf("unexpected beat node %0d last %0b status %0d",
                                         rsp_bus.node, rsp_bus.last, rsp_bus.status));
            end else begin
               oldest_visit = expected_visits.pop_front();
               if (rsp_bus.node !== oldest_visit.node)
                  report_mismatch($sformatf("node %0d, expected %0d",
                                            rsp_bus.node, oldest_visit.node));
               if (rsp_bus.last !== oldest_visit.last)
                  report_mismatch($sformatf("last %0b on node %0d, expected %0b",
                                            rsp_bus.last, oldest_visit.node,
                                            oldest_visit.last));
               if (rsp_bus.status !== oldest_visit.status)
                  report_mismatch($sformatf("status %0d on node %0d, expected %0d",
                                            rsp_bus.status, oldest_visit.node,
                                            oldest_visit.status));
            end
         end
         rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers.
   // ---------------------------------------------------------------------
   task automatic queue_request(func_type func, int unsigned from_node,
                                int unsigned to_node);
      dfs_request_type r;
      r.func      = func;
      r.from_node = NODE_W'(from_node);
      r.to_node   = NODE_W'(to_node);
      pending_requests.push_back(r);
      queued_items++;
   endtask

   // Mostly nodes in range, now and then any 6-bit index to provoke range errors.
   function automatic int unsigned pick_node(int unsigned n);
      if ($urandom_range(6) == 0) return $urandom_range(NODES - 1);
      return $urandom_range(n - 1);
   endfunction

   // A small random graph update followed by one or two walks over it. The
   // matrix is cleared only sometimes, so edges left over from a larger node
   // count turn into stale edges that the walk must ignore.
   task automatic queue_episode(int unsigned n);
      if ($urandom_range(5) == 0)
         queue_request(FUNC_CLEAR, $urandom_range(NODES - 1), $urandom_range(NODES - 1));
      repeat ($urandom_range(10, 2)) begin
         if ($urandom_range(11) == 0)
            queue_request(FUNC_NOP, $urandom_range(NODES - 1), $urandom_range(NODES - 1));
         else
            queue_request(FUNC_ADD_EDGE, pick_node(n), pick_node(n));
      end
      repeat ($urandom_range(2, 1))
         queue_request(FUNC_TRAVERSE, pick_node(n), $urandom_range(NODES - 1));
   endtask

   // A hub that points at every other node, plus a few edges out of its
   // lowest neighbor: the walk fills the stack with the whole graph at once
   // and then pops many nodes that are already visited.
   task automatic queue_dense_graph(int unsigned n);
      int unsigned hub;
      int unsigned first_child;
      hub = $urandom_range(n - 1);
      first_child = (hub == 0) ? 1 : 0;
      queue_request(FUNC_CLEAR, $urandom_range(NODES - 1), $urandom_range(NODES - 1));
      for (int j = 0; j < n; j++) begin
         if (j != hub) queue_request(FUNC_ADD_EDGE, hub, j);
      end
      repeat (4) queue_request(FUNC_ADD_EDGE, first_child, $urandom_range(n - 1));
      queue_request(FUNC_TRAVERSE, hub, $urandom_range(NODES - 1));
   endtask

   // Returns once every queued beat is accepted, every expected visit has
   // arrived and the block has had time to finish a trailing add or clear.
   task automatic wait_until_drained();
      do @(negedge clock);
      while (pending_requests.size() != 0 || req_bus.valid || expected_visits.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Register write in a setup and an access phase; the register takes the value at the access edge.
   task automatic write_node_count(int unsigned value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= CSR_ADDR_W'(NODE_COUNT_ADDR);
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      node_count_shadow = value[COUNT_W-1:0];
      settings_used++;
   endtask

   // ---------------------------------------------------------------------
   // Test sequence.
   // ---------------------------------------------------------------------
   initial begin
      int unsigned n;
      int unsigned phase_start;

      reset             = 1'b1;
      req_bus.valid     = 1'b0;
      req_bus.func      = FUNC_NOP;
      req_bus.from_node = '0;
      req_bus.to_node   = '0;
      rsp_bus.ready     = 1'b0;
      csr_psel          = 1'b0;
      csr_penable       = 1'b0;
      csr_pwrite        = 1'b0;
      csr_paddr         = '0;
      csr_pwdata        = '0;
      node_count_shadow = NODE_COUNT_RESET;
      visited_nodes     = '0;
      stack_level       = 0;
      push_dropped      = 1'b0;
      for (int i = 0; i < NODES; i++) adj_rows[i] = '0;
      send_idle_pct     = 34;
      recv_idle_pct     = 64;
      queued_items      = 0;
      accepted_requests = 0;
      checked_visits    = 0;
      mismatch_count    = 0;
      traversal_count   = 0;
      overflow_count    = 0;
      range_error_count = 0;
      settings_used     = 0;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed part, reset node count of 64: the corner nodes, a self loop,
      // a node with no edges and the unused function code.
      queue_request(FUNC_ADD_EDGE, 0, 63);
      queue_request(FUNC_ADD_EDGE, 63, 0);
      queue_request(FUNC_ADD_EDGE, 63, 63);
      queue_request(FUNC_ADD_EDGE, 0, 1);
      queue_request(FUNC_ADD_EDGE, 1, 62);
      queue_request(FUNC_TRAVERSE, 0, 0);
      queue_request(FUNC_TRAVERSE, 63, 63);
      queue_request(FUNC_TRAVERSE, 5, 0);
      queue_request(FUNC_NOP, 63, 63);
      wait_until_drained();

      // Three live nodes: the edges into 62 and 63 are now stale, and every
      // index from 3 up is out of range for both edge ends and start nodes.
      write_node_count(3);
      queue_request(FUNC_TRAVERSE, 0, 0);
      queue_request(FUNC_ADD_EDGE, 0, 3);
      queue_request(FUNC_ADD_EDGE, 3, 0);
      queue_request(FUNC_TRAVERSE, 3, 0);
      queue_request(FUNC_ADD_EDGE, 2, 2);
      queue_request(FUNC_ADD_EDGE, 1, 2);
      queue_request(FUNC_TRAVERSE, 1, 0);
      queue_request(FUNC_CLEAR, 0, 0);
      queue_request(FUNC_TRAVERSE, 0, 0);
      wait_until_drained();

      // A register value of zero leaves a single node.
      write_node_count(0);
      queue_request(FUNC_ADD_EDGE, 0, 0);
      queue_request(FUNC_ADD_EDGE, 0, 1);
      queue_request(FUNC_TRAVERSE, 0, 0);
      queue_request(FUNC_TRAVERSE, 1, 0);
      wait_until_drained();

      // Random part. Each phase runs at its own node count; the idling
      // pattern moves from a slow receiver to a slow sender to none at all.
      for (int p = 0; p < PHASES; p++) begin
         case (p / 3)
            0: begin
               send_idle_pct = 34;
               recv_idle_pct = 64;
            end
            1: begin
               send_idle_pct = 64;
               recv_idle_pct = 34;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         write_node_count(phase_node_counts[p]);
         n = effective_nodes();
         if (p == 2) queue_dense_graph(n);
         phase_start = queued_items;
         while (queued_items - phase_start < PHASE_ITEMS) queue_episode(n);
         wait_until_drained();
      end

      $display("Run covered %0d request beats, %0d walks (%0d with dropped pushes)",
               accepted_requests, traversal_count, overflow_count);
      $display("and %0d response beats, %0d range errors, over %0d node-count writes.",
               checked_visits, range_error_count, settings_used);
      if (mismatch_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run of the sequence above.
   initial begin
      #40_000_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule

>>> filelist.f
+incdir+rtl
rtl/amdfs_pkg.sv
rtl/amdfs_if.sv
rtl/amdfs_adj_mem.sv
rtl/amdfs_stack_mem.sv
rtl/amdfs_seq.sv
rtl/adjacency_matrix_dfs_order_unit.sv
rtl/amdfs_checker.sv
verif/tb.sv
